[hdl/edge_record_swap_remove_table_macros.svh]
// Assertion macros for the edge record table.
// Used by edge_record_swap_remove_table.sv; expects clk and arst_n in scope.
`ifndef EDGE_RECORD_SWAP_REMOVE_TABLE_MACROS_SVH
`define EDGE_RECORD_SWAP_REMOVE_TABLE_MACROS_SVH

// same-cycle implication
`define ERST_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ERST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/erst_pkg.sv]
// Package for the edge record table: sizes, codes, record and response types.
// No dependencies.
package erst_pkg;

	localparam int CAPACITY  = 256;
	localparam int NODE_BITS = 16;
	localparam int EDGE_BITS = 16;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = 8;
	localparam int TAG_W     = 8;
	localparam int FUNC_W    = 3;
	localparam int STAT_W    = 2;

	localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_KEY = 3'd1;
	localparam logic [FUNC_W-1:0] FN_IDX = 3'd2;
	localparam logic [FUNC_W-1:0] FN_RD  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLR = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [NODE_BITS-1:0] from;
		logic [NODE_BITS-1:0] dest;
		logic [EDGE_BITS-1:0] edge_id;
		logic [TAG_W-1:0]     tag;
	} entry_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [IDX_W-1:0]     hit;
		logic [NODE_BITS-1:0] from;
		logic [NODE_BITS-1:0] dest;
		logic [EDGE_BITS-1:0] edge_id;
		logic [TAG_W-1:0]     tag;
	} resp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SRCH,
		ST_MOVE,
		ST_RD
	} state_t;

endpackage

[hdl/erst_mem.sv]
// Record store: one write port, one read port, registered read data.
// Depends on erst_pkg.
module erst_mem import erst_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata
);

	entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/edge_record_swap_remove_table.sv]
// Top level of the edge record table: sequencer, count and result register.
// Depends on erst_pkg, erst_mem and edge_record_swap_remove_table_macros.svh.
//
// An item is taken when start is high and busy is low; its result appears on the
// result ports for one cycle with done high and cannot be held off. Add, clear and
// unused codes give their result the cycle after the item is taken. A valid read at
// index or remove by index first reads the record memory in ST_RD or ST_MOVE. Remove
// by key walks the table through the single read port of the record memory, one
// entry per cycle: a hit goes on to ST_MOVE, a miss ends the search at the last
// entry, and an empty table gives a miss directly from idle. busy is high while a
// read, search or move is under way; a new item may be taken in the cycle its
// predecessor's result is shown.
`include "edge_record_swap_remove_table_macros.svh"

module edge_record_swap_remove_table import erst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [FUNC_W-1:0]    func,
	input  logic [NODE_BITS-1:0] node_from,
	input  logic [NODE_BITS-1:0] node_dest,
	input  logic [EDGE_BITS-1:0] edge_id,
	input  logic [IDX_W-1:0]     index,
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [CNT_W-1:0]     entry_count,
	output logic [IDX_W-1:0]     hit_index,
	output logic [NODE_BITS-1:0] out_from,
	output logic [NODE_BITS-1:0] out_dest,
	output logic [EDGE_BITS-1:0] out_edge,
	output logic [TAG_W-1:0]     out_tag
);

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q, cnt_d;
	logic                 done_q;
	resp_t                rsp_q, rsp_d;
	logic                 rsp_vld;
	logic [FUNC_W-1:0]    func_q;
	logic [NODE_BITS-1:0] key_from_q, key_dest_q;
	logic [ADDR_W-1:0]    tgt_q, tgt_d;
	logic [ADDR_W-1:0]    addr_s1, addr_d;

	logic                 mem_we, mem_re;
	logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
	entry_t               mem_wdata, mem_rdata;

	logic [ADDR_W-1:0]    last;
	logic                 idx_ok, is_full, is_empty, key_hit, at_last;

	erst_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign last     = ADDR_W'(count_q - 1'b1);
	assign idx_ok   = CNT_W'(index) < count_q;
	assign is_full  = count_q == CNT_W'(CAPACITY);
	assign is_empty = count_q == '0;
	assign key_hit  = (mem_rdata.from == key_from_q) && (mem_rdata.dest == key_dest_q);
	assign at_last  = addr_s1 == last;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (func == FN_KEY && !is_empty) begin
						state_d = ST_SRCH;
					end else if (func == FN_IDX && idx_ok) begin
						state_d = ST_MOVE;
					end else if (func == FN_RD && idx_ok) begin
						state_d = ST_RD;
					end
				end
			end
			ST_SRCH: begin
				if (key_hit) begin
					state_d = ST_MOVE;
				end else if (at_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_MOVE: state_d = ST_IDLE;
			ST_RD:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory control, count and result
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[ADDR_W-1:0];
		mem_wdata = '{from: node_from, dest: node_dest, edge_id: edge_id,
			tag: TAG_W'(count_q)};
		mem_re    = 1'b0;
		mem_raddr = ADDR_W'(addr_s1 + 1'b1);
		rsp_vld   = 1'b0;
		rsp_d     = '0;
		cnt_d     = count_q;
		tgt_d     = tgt_q;
		addr_d    = addr_s1;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (func)
						FN_ADD: begin
							rsp_vld = 1'b1;
							if (is_full) begin
								rsp_d.status = STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								rsp_d.hit = IDX_W'(count_q);
								cnt_d     = CNT_W'(count_q + 1'b1);
							end
						end
						FN_KEY: begin
							if (is_empty) begin
								rsp_vld      = 1'b1;
								rsp_d.status = STAT_MISS;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								addr_d    = '0;
							end
						end
						FN_IDX: begin
							if (idx_ok) begin
								mem_re    = 1'b1;
								mem_raddr = last;
								tgt_d     = ADDR_W'(index);
							end else begin
								rsp_vld      = 1'b1;
								rsp_d.status = STAT_MISS;
							end
						end
						FN_RD: begin
							if (idx_ok) begin
								mem_re    = 1'b1;
								mem_raddr = ADDR_W'(index);
							end else begin
								rsp_vld      = 1'b1;
								rsp_d.status = STAT_MISS;
							end
						end
						FN_CLR: begin
							rsp_vld = 1'b1;
							cnt_d   = '0;
						end
						default: begin
							rsp_vld = 1'b1;
						end
					endcase
				end
			end
			ST_SRCH: begin
				if (key_hit) begin
					mem_re    = 1'b1;
					mem_raddr = last;
					tgt_d     = addr_s1;
				end else if (at_last) begin
					rsp_vld      = 1'b1;
					rsp_d.status = STAT_MISS;
				end else begin
					mem_re = 1'b1;
					addr_d = ADDR_W'(addr_s1 + 1'b1);
				end
			end
			ST_MOVE: begin
				// last entry lands on the removed slot
				mem_we    = 1'b1;
				mem_waddr = tgt_q;
				mem_wdata = mem_rdata;
				cnt_d     = CNT_W'(count_q - 1'b1);
				rsp_vld   = 1'b1;
				if (func_q == FN_KEY) begin
					rsp_d.hit = IDX_W'(tgt_q);
				end
			end
			ST_RD: begin
				rsp_vld       = 1'b1;
				rsp_d.from    = mem_rdata.from;
				rsp_d.dest    = mem_rdata.dest;
				rsp_d.edge_id = mem_rdata.edge_id;
				rsp_d.tag     = mem_rdata.tag;
			end
			default: begin
				rsp_vld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= cnt_d;
			done_q  <= rsp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			func_q     <= func;
			key_from_q <= node_from;
			key_dest_q <= node_dest;
		end
		tgt_q   <= tgt_d;
		addr_s1 <= addr_d;
		if (rsp_vld) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign done        = done_q;
	assign status      = rsp_q.status;
	assign entry_count = count_q;
	assign hit_index   = rsp_q.hit;
	assign out_from    = rsp_q.from;
	assign out_dest    = rsp_q.dest;
	assign out_edge    = rsp_q.edge_id;
	assign out_tag     = rsp_q.tag;

	`ERST_IMPLIES(a_cnt_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`ERST_NEXT(a_add_done, start && !busy && func == FN_ADD && !is_full, done && entry_count == CNT_W'($past(count_q) + 1'b1), "add did not complete next cycle")
	`ERST_IMPLIES(a_srch_nowr, state_q == ST_SRCH, !mem_we, "memory written during search")
	`ERST_IMPLIES(a_done_idle, done, !busy, "result shown while busy")

endmodule
